### design/i2c_master_transaction_sequencer_unit_defines.svh
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle check on clk, held off while rst_n is low.
`define I2CMTS_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmts check failed");

// Next-cycle check on clk, held off while rst_n is low.
`define I2CMTS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmts check failed");

`endif

### design/i2cmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

  // input word
  typedef struct packed {
    logic        func;
    logic [7:0]  dev_addr;
    logic [15:0] address_count;
    logic [15:0] write_count;
    logic [15:0] read_count;
    logic [4:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] bus_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [1:0] outcome;
    logic [4:0] fail_status;
  } out_item_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_W_START = 8'b0000_0010,
    PH_W_SLA   = 8'b0000_0100,
    PH_W_DATA  = 8'b0000_1000,
    PH_R_START = 8'b0001_0000,
    PH_R_SLA   = 8'b0010_0000,
    PH_R_ACK   = 8'b0100_0000,
    PH_R_NACK  = 8'b1000_0000
  } phase_t;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_DONE  = 1'b1;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RACK  = 3'd3;
  localparam logic [2:0] CMD_RNACK = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  localparam logic [1:0] OUTC_OK    = 2'd0;
  localparam logic [1:0] OUTC_NAK   = 2'd1;
  localparam logic [1:0] OUTC_ABORT = 2'd2;

  // bus engine status codes (upper five status bits)
  localparam logic [4:0] ST_START    = 5'h01;
  localparam logic [4:0] ST_RSTART   = 5'h02;
  localparam logic [4:0] ST_SLAW_ACK = 5'h03;
  localparam logic [4:0] ST_SLAW_NAK = 5'h04;
  localparam logic [4:0] ST_DATA_ACK = 5'h05;
  localparam logic [4:0] ST_DATA_NAK = 5'h06;
  localparam logic [4:0] ST_SLAR_ACK = 5'h08;
  localparam logic [4:0] ST_SLAR_NAK = 5'h09;
  localparam logic [4:0] ST_RX_ACK   = 5'h0A;
  localparam logic [4:0] ST_RX_NACK  = 5'h0B;

  localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
  localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

endpackage

`default_nettype wire

### design/i2cmts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface i2cmts_in_if import i2cmts_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmts_out_if import i2cmts_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/i2cmts_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_in_stage import i2cmts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  i2cmts_in_if.sink   in_word,
  input  logic        item_take,
  output logic        item_valid,
  output in_item_t    item
);

  logic     in_v_r;
  logic     in_v_nxt;
  in_item_t in_d_r;
  logic     accept;

  assign in_word.ready = !in_v_r || item_take;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (item_take) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_d_r <= in_word.data;
    end
  end

  assign item_valid = in_v_r;
  assign item       = in_d_r;

endmodule

`default_nettype wire

### design/i2cmts_step.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_step import i2cmts_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  in_item_t                item,
  input  phase_t                  phase,
  input  logic [COUNT_WIDTH:0]    btw,
  input  logic [COUNT_WIDTH-1:0]  btr,
  input  logic [7:0]              taddr,
  input  logic                    wrote,
  output out_item_t               res,
  output phase_t                  phase_nxt,
  output logic [COUNT_WIDTH:0]    btw_nxt,
  output logic [COUNT_WIDTH-1:0]  btr_nxt,
  output logic [7:0]              taddr_nxt,
  output logic                    wrote_nxt
);

  localparam logic [COUNT_WIDTH-1:0] RD_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [COUNT_WIDTH:0]   WR_ONE = {{COUNT_WIDTH{1'b0}}, 1'b1};

  logic [4:0]             st;
  logic [COUNT_WIDTH:0]   wr_sum;
  logic [COUNT_WIDTH:0]   btw_dec;
  logic [COUNT_WIDTH-1:0] btr_dec;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [2:0]             rd_cmd;
  phase_t                 rd_phase;
  logic [4:0]             ok_code;
  logic [4:0]             nak_code;
  logic [4:0]             rs_code;
  logic                   fin_ok;
  logic                   fin_nak;
  logic                   fin_abort;

  assign st      = item.bus_status;
  assign rd_cnt  = item.read_count[COUNT_WIDTH-1:0];
  assign wr_sum  = {1'b0, item.address_count[COUNT_WIDTH-1:0]}
                 + {1'b0, item.write_count[COUNT_WIDTH-1:0]};
  assign btw_dec = btw - WR_ONE;
  assign btr_dec = btr - RD_ONE;
  // last read goes out with NACK
  assign rd_cmd   = (btr_dec == '0) ? CMD_RNACK : CMD_RACK;
  assign rd_phase = (btr_dec == '0) ? PH_R_NACK : PH_R_ACK;
  assign ok_code  = (phase == PH_W_SLA) ? ST_SLAW_ACK : ST_DATA_ACK;
  assign nak_code = (phase == PH_W_SLA) ? ST_SLAW_NAK : ST_DATA_NAK;
  assign rs_code  = wrote ? ST_RSTART : ST_START;

  always_comb begin
    res       = '0;
    phase_nxt = phase;
    btw_nxt   = btw;
    btr_nxt   = btr;
    taddr_nxt = taddr;
    wrote_nxt = wrote;
    fin_ok    = 1'b0;
    fin_nak   = 1'b0;
    fin_abort = 1'b0;

    if (item.func == FUNC_BEGIN) begin
      // begin while busy is dropped
      if (phase == PH_IDLE) begin
        taddr_nxt = item.dev_addr;
        btw_nxt   = wr_sum;
        btr_nxt   = rd_cnt;
        wrote_nxt = (wr_sum != '0);
        if (wr_sum != '0) begin
          res.command = CMD_START;
          phase_nxt   = PH_W_START;
        end else if (rd_cnt != '0) begin
          res.command = CMD_START;
          phase_nxt   = PH_R_START;
        end else begin
          fin_ok = 1'b1;
        end
      end
    end else begin
      case (phase)
        PH_W_START: begin
          if (st != ST_START) begin
            fin_abort = 1'b1;
          end else begin
            res.command  = CMD_SEND;
            res.bus_byte = taddr & ADDR_WRITE_MASK;
            phase_nxt    = PH_W_SLA;
          end
        end
        PH_W_SLA, PH_W_DATA: begin
          if (st == nak_code) begin
            res.command = CMD_STOP;
            fin_nak     = 1'b1;
          end else if (st != ok_code) begin
            fin_abort = 1'b1;
          end else if (btw != '0) begin
            res.command  = CMD_SEND;
            res.bus_byte = item.tx_byte;
            btw_nxt      = btw_dec;
            phase_nxt    = PH_W_DATA;
          end else if (btr != '0) begin
            res.command = CMD_START;
            phase_nxt   = PH_R_START;
          end else begin
            res.command = CMD_STOP;
            fin_ok      = 1'b1;
          end
        end
        PH_R_START: begin
          if (st != rs_code) begin
            fin_abort = 1'b1;
          end else begin
            res.command  = CMD_SEND;
            res.bus_byte = taddr | ADDR_READ_BIT;
            phase_nxt    = PH_R_SLA;
          end
        end
        PH_R_SLA: begin
          if (st == ST_SLAR_NAK) begin
            res.command = CMD_STOP;
            fin_nak     = 1'b1;
          end else if (st != ST_SLAR_ACK) begin
            fin_abort = 1'b1;
          end else begin
            res.command = rd_cmd;
            btr_nxt     = btr_dec;
            phase_nxt   = rd_phase;
          end
        end
        PH_R_ACK: begin
          if (st != ST_RX_ACK) begin
            fin_abort = 1'b1;
          end else begin
            res.rx_valid = 1'b1;
            res.rx_data  = item.rx_byte;
            res.command  = rd_cmd;
            btr_nxt      = btr_dec;
            phase_nxt    = rd_phase;
          end
        end
        PH_R_NACK: begin
          if (st != ST_RX_NACK) begin
            fin_abort = 1'b1;
          end else begin
            res.rx_valid = 1'b1;
            res.rx_data  = item.rx_byte;
            res.command  = CMD_STOP;
            fin_ok       = 1'b1;
          end
        end
        default: begin
          // completion while idle: nothing to do
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (fin_ok || fin_nak || fin_abort) begin
      res.done_res = 1'b1;
      phase_nxt    = PH_IDLE;
      if (fin_nak) begin
        res.outcome     = OUTC_NAK;
        res.fail_status = st;
      end else if (fin_abort) begin
        res.outcome     = OUTC_ABORT;
        res.fail_status = st;
      end else begin
        res.outcome = OUTC_OK;
      end
    end
  end

endmodule

`default_nettype wire

### design/i2cmts_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_out_stage import i2cmts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_load,
  input  out_item_t    res,
  output logic         res_room,
  i2cmts_out_if.source out_word
);

  logic      out_v_r;
  logic      out_v_nxt;
  out_item_t out_d_r;

  // room when empty or the current word leaves this cycle
  assign res_room = !out_v_r || out_word.ready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (res_load) begin
      out_v_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_d_r <= res;
    end
  end

  assign out_word.valid = out_v_r;
  assign out_word.data  = out_d_r;

endmodule

`default_nettype wire

### design/i2c_master_transaction_sequencer_unit.sv
// I2C master write-then-read sequencer, sitting above a byte-level bus engine.
// in_word (valid/ready): func 0 begins a transaction (device address, address,
//   write and read byte counts); func 1 reports a finished bus command with
//   its status code, the received byte and the next byte to send.
// out_word (valid/ready): exactly one word per input word: the next bus
//   command and its byte, a received byte for the host, and on the last step
//   done_res with the outcome (ok, NAK then STOP, abort without STOP).
// Path: the input register, one pass of step logic, then the result register,
//   loaded when it has room.
// Throughput: one word per cycle while the result register has room; the step
//   logic is combinational on the registered input word and the sequencer state.
// Stall: while out_word.ready is low the result register holds; one more
//   word is taken into the input register, then in_word.ready drops.
// Reset (rst_n low, synchronous): both registers empty, phase idle, counts
//   and address cleared. Begin while busy and completion while idle both
//   give an all-zero word.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_transaction_sequencer_unit_defines.svh"

module i2c_master_transaction_sequencer_unit import i2cmts_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cmts_in_if.sink    in_word,
  i2cmts_out_if.source out_word
);

  logic                   item_valid;
  in_item_t               item;
  logic                   res_room;
  logic                   adv;
  out_item_t              res;
  logic                   rx_cmd_ok;   // command legal alongside a received byte

  // sequencer state
  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [COUNT_WIDTH:0]   btw_r;       // address + write bytes left
  logic [COUNT_WIDTH:0]   btw_nxt;
  logic [COUNT_WIDTH-1:0] btr_r;       // reads not yet issued
  logic [COUNT_WIDTH-1:0] btr_nxt;
  logic [7:0]             taddr_r;
  logic [7:0]             taddr_nxt;
  logic                   wrote_r;     // transaction had a write phase
  logic                   wrote_nxt;

  // one step per cycle whenever the result register has room
  assign adv = item_valid && res_room;

  i2cmts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .item_take  (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cmts_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .item      (item),
    .phase     (phase_r),
    .btw       (btw_r),
    .btr       (btr_r),
    .taddr     (taddr_r),
    .wrote     (wrote_r),
    .res       (res),
    .phase_nxt (phase_nxt),
    .btw_nxt   (btw_nxt),
    .btr_nxt   (btr_nxt),
    .taddr_nxt (taddr_nxt),
    .wrote_nxt (wrote_nxt)
  );

  i2cmts_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (adv),
    .res      (res),
    .res_room (res_room),
    .out_word (out_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      btw_r   <= '0;
      btr_r   <= '0;
      taddr_r <= '0;
      wrote_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      btw_r   <= btw_nxt;
      btr_r   <= btr_nxt;
      taddr_r <= taddr_nxt;
      wrote_r <= wrote_nxt;
    end
  end

  assign rx_cmd_ok = (out_word.data.command == CMD_RACK) ||
                     (out_word.data.command == CMD_RNACK) ||
                     (out_word.data.command == CMD_STOP);

  // a finishing step always leaves the sequencer idle
  `I2CMTS_CHECK_NEXT(a_done_to_idle, adv && res.done_res, phase_r == PH_IDLE)
  // the NACK read is issued only when no reads remain
  `I2CMTS_CHECK_NOW(a_nack_last, phase_r == PH_R_NACK, btr_r == '0)
  // a received byte comes with a read or the closing STOP
  `I2CMTS_CHECK_NOW(a_rx_cmd, out_word.valid && out_word.data.rx_valid, rx_cmd_ok)

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import i2cmts_pkg::*;

  // Sequencer state as the testbench tracks it.
  typedef struct packed {
    phase_t      ph;
    logic [16:0] wr_left;   // address plus write bytes still to send
    logic [15:0] rd_left;   // reads not yet issued
    logic [7:0]  addr;      // device address of the open transaction
    logic        wrote;     // transaction had a write part
  } seq_state_t;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with work outstanding and no handshake
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int MAX_REPORTS    = 40;

  logic clk;
  logic rst_n;

  i2cmts_in_if  in_if ();
  i2cmts_out_if out_if ();

  i2c_master_transaction_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if)
  );

  in_item_t   pending_words[$];    // words waiting to be offered
  out_item_t  expected_steps[$];   // predicted result words, oldest first
  seq_state_t seq_model;           // tracks accepted words
  seq_state_t gen_model;           // tracks queued words, steers the generator

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_go;
  int unsigned hold_left;
  int          queued_words;
  int          error_count;
  int          result_index;
  int          quiet_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Word that closes a transaction.
  function automatic out_item_t closing_word(logic [2:0] cmd, logic [1:0] how,
                                             logic [4:0] code);
    out_item_t r;
    r = '0;
    r.command     = cmd;
    r.done_res    = 1'b1;
    r.outcome     = how;
    r.fail_status = (how != OUTC_OK) ? code : 5'd0;
    return r;
  endfunction

  // One input word in, one result word out; advances the tracked state.
  function automatic out_item_t next_bus_step(inout seq_state_t s, input in_item_t w);
    out_item_t  r;
    logic [4:0] st;
    logic       read_next;
    r = '0;
    st = w.bus_status;
    read_next = 1'b0;
    if (w.func == FUNC_BEGIN) begin
      // begin while busy is dropped with an all-zero word
      if (s.ph == PH_IDLE) begin
        s.addr    = w.dev_addr;
        s.wr_left = {1'b0, w.address_count} + {1'b0, w.write_count};
        s.rd_left = w.read_count;
        s.wrote   = (s.wr_left != '0);
        if (s.wrote) begin
          r.command = CMD_START;
          s.ph = PH_W_START;
        end else if (s.rd_left != '0) begin
          r.command = CMD_START;
          s.ph = PH_R_START;
        end else begin
          r = closing_word(CMD_NONE, OUTC_OK, 5'd0);   // empty transaction
        end
      end
    end else begin
      case (s.ph)
        PH_W_START: begin
          if (st != ST_START) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else begin
            r.command  = CMD_SEND;
            r.bus_byte = s.addr & ADDR_WRITE_MASK;
            s.ph = PH_W_SLA;
          end
        end
        PH_W_SLA, PH_W_DATA: begin
          if (st == ((s.ph == PH_W_SLA) ? ST_SLAW_NAK : ST_DATA_NAK)) begin
            r = closing_word(CMD_STOP, OUTC_NAK, st);
          end else if (st != ((s.ph == PH_W_SLA) ? ST_SLAW_ACK : ST_DATA_ACK)) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else if (s.wr_left != '0) begin
            r.command  = CMD_SEND;
            r.bus_byte = w.tx_byte;
            s.wr_left  = s.wr_left - 17'd1;
            s.ph = PH_W_DATA;
          end else if (s.rd_left != '0) begin
            r.command = CMD_START;   // repeated START
            s.ph = PH_R_START;
          end else begin
            r = closing_word(CMD_STOP, OUTC_OK, 5'd0);
          end
        end
        PH_R_START: begin
          // plain START for read-only, repeated START after writes
          if (st != (s.wrote ? ST_RSTART : ST_START)) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else begin
            r.command  = CMD_SEND;
            r.bus_byte = s.addr | ADDR_READ_BIT;
            s.ph = PH_R_SLA;
          end
        end
        PH_R_SLA: begin
          if (st == ST_SLAR_NAK) begin
            r = closing_word(CMD_STOP, OUTC_NAK, st);
          end else if (st != ST_SLAR_ACK) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else begin
            read_next = 1'b1;
          end
        end
        PH_R_ACK: begin
          // a bad status on a read drops the byte
          if (st != ST_RX_ACK) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else begin
            r.rx_valid = 1'b1;
            r.rx_data  = w.rx_byte;
            read_next  = 1'b1;
          end
        end
        PH_R_NACK: begin
          if (st != ST_RX_NACK) begin
            r = closing_word(CMD_NONE, OUTC_ABORT, st);
          end else begin
            r = closing_word(CMD_STOP, OUTC_OK, 5'd0);
            r.rx_valid = 1'b1;
            r.rx_data  = w.rx_byte;
          end
        end
        default: ;   // completion while idle: all-zero word
      endcase
      if (read_next) begin
        s.rd_left = s.rd_left - 16'd1;
        if (s.rd_left == '0) begin
          r.command = CMD_RNACK;
          s.ph = PH_R_NACK;
        end else begin
          r.command = CMD_RACK;
          s.ph = PH_R_ACK;
        end
      end
    end
    if (r.done_res) s.ph = PH_IDLE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Status that lets the transaction move on from this phase.
  function automatic logic [4:0] ack_code(seq_state_t s);
    case (s.ph)
      PH_W_SLA:   return ST_SLAW_ACK;
      PH_W_DATA:  return ST_DATA_ACK;
      PH_R_START: return s.wrote ? ST_RSTART : ST_START;
      PH_R_SLA:   return ST_SLAR_ACK;
      PH_R_ACK:   return ST_RX_ACK;
      PH_R_NACK:  return ST_RX_NACK;
      default:    return ST_START;
    endcase
  endfunction

  // NAK for this phase; phases without one give back the ack code.
  function automatic logic [4:0] nak_code(seq_state_t s);
    case (s.ph)
      PH_W_SLA:  return ST_SLAW_NAK;
      PH_W_DATA: return ST_DATA_NAK;
      PH_R_SLA:  return ST_SLAR_NAK;
      default:   return ack_code(s);
    endcase
  endfunction

  task automatic queue_word(in_item_t w);
    pending_words.push_back(w);
    void'(next_bus_step(gen_model, w));
    queued_words++;
  endtask

  // Fields that the word's kind ignores still get random values.
  task automatic queue_begin(logic [7:0] a, logic [15:0] ac, logic [15:0] wc,
                             logic [15:0] rd);
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom});
    w.func          = FUNC_BEGIN;
    w.dev_addr      = a;
    w.address_count = ac;
    w.write_count   = wc;
    w.read_count    = rd;
    queue_word(w);
  endtask

  task automatic queue_event(logic [4:0] st);
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom});
    w.func       = FUNC_DONE;
    w.bus_status = st;
    queue_word(w);
  endtask

  // One transaction: mostly well formed, with NAKs, bad codes and stray
  // begins mixed in. Huge counts only run until a forced fault.
  task automatic queue_transaction();
    logic        big;
    int unsigned fault_odds;
    int          steps;
    logic [4:0]  ok;
    logic [4:0]  st;
    big = ($urandom_range(19) == 0);
    if ($urandom_range(24) == 0) queue_event(5'($urandom_range(31)));   // stray completion
    if (big)
      queue_begin(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      queue_begin(8'($urandom), 16'($urandom_range(2)), 16'($urandom_range(3)),
                  16'($urandom_range(4)));
    fault_odds = big ? 6 : 14;
    steps = 0;
    while (gen_model.ph != PH_IDLE) begin
      ok = ack_code(gen_model);
      if ($urandom_range(29) == 0) begin
        queue_begin(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (steps >= 30 || $urandom_range(fault_odds - 1) == 0) begin
        st = nak_code(gen_model);
        if (st == ok || $urandom_range(1) == 1) begin
          do st = 5'($urandom_range(31)); while (st == ok);
        end
        queue_event(st);
      end else begin
        queue_event(ok);
      end
      steps++;
    end
  endtask

  task automatic queue_directed();
    queue_begin(8'h00, 16'd0, 16'd0, 16'd0);        // empty transaction
    queue_event(ST_START);                          // completion while idle
    // write only
    queue_begin(8'hFF, 16'd1, 16'd1, 16'd0);
    queue_event(ST_START);
    queue_event(ST_SLAW_ACK);
    queue_event(ST_DATA_ACK);
    queue_event(ST_DATA_ACK);
    // read only, plain START
    queue_begin(8'h00, 16'd0, 16'd0, 16'd2);
    queue_event(ST_START);
    queue_event(ST_SLAR_ACK);
    queue_event(ST_RX_ACK);
    queue_event(ST_RX_NACK);
    // write then read, with a begin while busy
    queue_begin(8'hA5, 16'd0, 16'd1, 16'd1);
    queue_begin(8'h5A, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(ST_START);
    queue_event(ST_SLAW_ACK);
    queue_event(ST_DATA_ACK);
    queue_event(ST_RSTART);
    queue_event(ST_SLAR_ACK);
    queue_event(ST_RX_NACK);
    // full counts, ended by a data NAK
    queue_begin(8'h7E, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(ST_START);
    queue_event(ST_SLAW_ACK);
    queue_event(ST_DATA_NAK);
  endtask

  // Sender pause: everything offered, accepted and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_if.valid || expected_steps.size() != 0);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int n_words,
                           logic hold, logic directed);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) begin
      // receiver holds off while the sender keeps offering words
      hold_go = 1'b1;
      @(negedge clk);
      hold_go = 1'b0;
    end
    if (directed) queue_directed();
    target = queued_words + n_words;
    while (queued_words < target) queue_transaction();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR %0t word %0d: %s", $time, result_index, msg);
  endtask

  task automatic check_word(out_item_t got, out_item_t want);
    if (got.command !== want.command)
      flag_error($sformatf("command %0d, want %0d", got.command, want.command));
    if (got.bus_byte !== want.bus_byte)
      flag_error($sformatf("bus_byte %h, want %h", got.bus_byte, want.bus_byte));
    if (got.rx_valid !== want.rx_valid)
      flag_error($sformatf("rx_valid %b, want %b", got.rx_valid, want.rx_valid));
    if (got.rx_data !== want.rx_data)
      flag_error($sformatf("rx_data %h, want %h", got.rx_data, want.rx_data));
    if (got.done_res !== want.done_res)
      flag_error($sformatf("done_res %b, want %b", got.done_res, want.done_res));
    if (got.outcome !== want.outcome)
      flag_error($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
    if (got.fail_status !== want.fail_status)
      flag_error($sformatf("fail_status %h, want %h", got.fail_status, want.fail_status));
  endtask

  // ---------------------------------------------------------------------------
  // Clock and initial drive values
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued words; the prediction is made on the handshake so
  // that the expectation order is exactly the acceptance order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_steps.push_back(next_bus_step(seq_model, in_if.data));
      // free slot: offer the next word unless the sender idles this cycle
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_words.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_steps.size() == 0)
          flag_error("result word with nothing expected");
        else
          check_word(out_if.data, expected_steps.pop_front());
        result_index++;
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_go)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Watchdog: only counts while work is outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (pending_words.size() == 0 && !in_if.valid && expected_steps.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT %0t: no handshake in %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Runs on the falling edge so queue and mode updates never
  // race the clocked processes.
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    queued_words   = 0;
    error_count    = 0;
    result_index   = 0;
    quiet_cycles   = 0;
    seq_model = '{ph: PH_IDLE, default: '0};
    gen_model = '{ph: PH_IDLE, default: '0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_phase(0, 0, 150, 1'b0, 1'b1);     // directed, then no idling
    run_phase(70, 0, 150, 1'b0, 1'b0);    // sender idle most cycles
    run_phase(0, 70, 150, 1'b0, 1'b0);    // receiver stalls most cycles
    run_phase(20, 20, 150, 1'b0, 1'b0);   // both, lightly
    run_phase(0, 0, 100, 1'b1, 1'b0);     // long hold-off: block fills, input stalls
    run_phase(0, 0, 100, 1'b0, 1'b0);

    // leave room for any stray result word
    repeat (10) @(negedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
